@@ design/sor_pkg.sv @@
// Package for the spiral reorder block: shared widths, codes, types and helpers.
// Used by sor_walker, spiral_order_reorder_top and sor_checker; depends on nothing.
package sor_pkg;

    localparam int DATA_W    = 32;
    localparam int DIM_W     = 4;
    localparam int TOT_W     = 2 * DIM_W;
    localparam int POS_W     = DIM_W + 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS = 2'd1;

    localparam logic [DIM_W-1:0] DIM_RESET = 4'd8;
    localparam logic signed [POS_W-1:0] POS_ONE = 6'sd1;

    typedef enum logic [2:0] {
        SP_IDLE,
        SP_CHECK,
        SP_TOP,
        SP_RIGHT,
        SP_BOT_CHK,
        SP_BOT,
        SP_LEFT_CHK,
        SP_LEFT
    } phase_t;

    typedef struct packed {
        logic             go;
        logic [DIM_W-1:0] rows;
        logic [DIM_W-1:0] cols;
        logic [TOT_W-1:0] total;
    } start_t;

    typedef struct packed {
        logic valid;
        logic last;
    } rd_req_t;

    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v,
                                                 input int unsigned maxv);
        logic [DIM_W-1:0] r;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (int'(v) > int'(maxv)) begin
            r = DIM_W'(maxv);
        end else begin
            r = v;
        end
        return r;
    endfunction

endpackage

@@ design/sor_walker.sv @@
// Spiral walker: steps the four bounds of the clockwise spiral and issues one store read per result.
// Depends on sor_pkg.
module sor_walker #(
    parameter int ADDR_W = 6
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sor_pkg::start_t       start,
    input  logic                  advance,
    output logic                  busy,
    output sor_pkg::rd_req_t      rd_req,
    output logic [ADDR_W-1:0]     rd_addr
);

    sor_pkg::phase_t                       state_reg, state_next;
    logic signed [sor_pkg::POS_W-1:0]      top_reg, top_next;
    logic signed [sor_pkg::POS_W-1:0]      bot_reg, bot_next;
    logic signed [sor_pkg::POS_W-1:0]      lft_reg, lft_next;
    logic signed [sor_pkg::POS_W-1:0]      rgt_reg, rgt_next;
    logic signed [sor_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic [sor_pkg::DIM_W-1:0]             cols_reg, cols_next;
    logic [sor_pkg::TOT_W-1:0]             total_reg, total_next;
    logic [sor_pkg::TOT_W-1:0]             cnt_reg, cnt_next;

    logic                                  emit;
    logic signed [sor_pkg::POS_W-1:0]      emit_row;
    logic signed [sor_pkg::POS_W-1:0]      emit_col;
    logic                                  fire;
    logic                                  last;
    logic [sor_pkg::TOT_W-1:0]             addr_full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= sor_pkg::SP_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_reg   <= top_next;
        bot_reg   <= bot_next;
        lft_reg   <= lft_next;
        rgt_reg   <= rgt_next;
        pos_reg   <= pos_next;
        cols_reg  <= cols_next;
        total_reg <= total_next;
    end

    assign last = (cnt_reg == (total_reg - sor_pkg::TOT_W'(1)));
    assign fire = emit && advance;

    always_comb
    begin
        state_next = state_reg;
        top_next   = top_reg;
        bot_next   = bot_reg;
        lft_next   = lft_reg;
        rgt_next   = rgt_reg;
        pos_next   = pos_reg;
        cols_next  = cols_reg;
        total_next = total_reg;
        emit       = 1'b0;
        emit_row   = top_reg;
        emit_col   = pos_reg;

        case (state_reg)
            sor_pkg::SP_IDLE:
            begin
                if (start.go)
                begin
                    top_next   = '0;
                    lft_next   = '0;
                    bot_next   = $signed({2'b00, start.rows}) - sor_pkg::POS_ONE;
                    rgt_next   = $signed({2'b00, start.cols}) - sor_pkg::POS_ONE;
                    cols_next  = start.cols;
                    total_next = start.total;
                    state_next = sor_pkg::SP_CHECK;
                end
            end
            sor_pkg::SP_CHECK:
            begin
                if ((top_reg <= bot_reg) && (lft_reg <= rgt_reg))
                begin
                    pos_next   = lft_reg;
                    state_next = sor_pkg::SP_TOP;
                end
                else
                begin
                    state_next = sor_pkg::SP_IDLE;
                end
            end
            sor_pkg::SP_TOP:
            begin
                if (pos_reg > rgt_reg)
                begin
                    top_next   = top_reg + sor_pkg::POS_ONE;
                    pos_next   = top_reg + sor_pkg::POS_ONE;
                    state_next = sor_pkg::SP_RIGHT;
                end
                else
                begin
                    emit     = 1'b1;
                    emit_row = top_reg;
                    emit_col = pos_reg;
                    pos_next = pos_reg + sor_pkg::POS_ONE;
                end
            end
            sor_pkg::SP_RIGHT:
            begin
                if (pos_reg > bot_reg)
                begin
                    rgt_next   = rgt_reg - sor_pkg::POS_ONE;
                    state_next = sor_pkg::SP_BOT_CHK;
                end
                else
                begin
                    emit     = 1'b1;
                    emit_row = pos_reg;
                    emit_col = rgt_reg;
                    pos_next = pos_reg + sor_pkg::POS_ONE;
                end
            end
            sor_pkg::SP_BOT_CHK:
            begin
                if (top_reg <= bot_reg)
                begin
                    pos_next   = rgt_reg;
                    state_next = sor_pkg::SP_BOT;
                end
                else
                begin
                    state_next = sor_pkg::SP_LEFT_CHK;
                end
            end
            sor_pkg::SP_BOT:
            begin
                if (pos_reg < lft_reg)
                begin
                    bot_next   = bot_reg - sor_pkg::POS_ONE;
                    state_next = sor_pkg::SP_LEFT_CHK;
                end
                else
                begin
                    emit     = 1'b1;
                    emit_row = bot_reg;
                    emit_col = pos_reg;
                    pos_next = pos_reg - sor_pkg::POS_ONE;
                end
            end
            sor_pkg::SP_LEFT_CHK:
            begin
                if (lft_reg <= rgt_reg)
                begin
                    pos_next   = bot_reg;
                    state_next = sor_pkg::SP_LEFT;
                end
                else
                begin
                    state_next = sor_pkg::SP_CHECK;
                end
            end
            sor_pkg::SP_LEFT:
            begin
                if (pos_reg < top_reg)
                begin
                    lft_next   = lft_reg + sor_pkg::POS_ONE;
                    state_next = sor_pkg::SP_CHECK;
                end
                else
                begin
                    emit     = 1'b1;
                    emit_row = pos_reg;
                    emit_col = lft_reg;
                    pos_next = pos_reg - sor_pkg::POS_ONE;
                end
            end
            default:
            begin
                state_next = sor_pkg::SP_IDLE;
            end
        endcase

        // A stalled result holds the walker in place.
        if (emit && !advance)
        begin
            pos_next = pos_reg;
        end
        if (fire && last)
        begin
            state_next = sor_pkg::SP_IDLE;
        end
    end

    always_comb
    begin
        cnt_next = cnt_reg;
        if (start.go && (state_reg == sor_pkg::SP_IDLE))
        begin
            cnt_next = '0;
        end
        else if (fire)
        begin
            cnt_next = cnt_reg + sor_pkg::TOT_W'(1);
        end
    end

    assign addr_full = ({{sor_pkg::DIM_W{1'b0}}, emit_row[sor_pkg::DIM_W-1:0]}
                        * {{sor_pkg::DIM_W{1'b0}}, cols_reg})
                     + {{sor_pkg::DIM_W{1'b0}}, emit_col[sor_pkg::DIM_W-1:0]};

    assign rd_addr      = ADDR_W'(addr_full);
    assign rd_req.valid = fire;
    assign rd_req.last  = last;
    assign busy         = (state_reg != sor_pkg::SP_IDLE);

endmodule

@@ design/spiral_order_reorder_top.sv @@
// Top level of the spiral reorder block: element store, load counter, config and output stages.
// Depends on sor_pkg and sor_walker.
//
//   channel | handshake            | payload
//   --------+----------------------+--------------------------------
//   in      | in_valid / in_ready  | element_value
//   out     | out_valid / out_ready| out_value, last_of_run
//   cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// Items are loaded into the store in order while the walker is idle. The item that
// completes the matrix starts the walker, which issues one store read per cycle unless the
// output stalls, and pauses at each pass boundary and each ring check.
// The input is held off while the walker runs. No clearing pass follows reset.
// A stalled output holds the read stage, which in turn holds the walker.
module spiral_order_reorder_top #(
    parameter int MAX_ROWS = 8,
    parameter int MAX_COLS = 8
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [sor_pkg::DATA_W-1:0]   element_value,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [sor_pkg::DATA_W-1:0]   out_value,
    output logic                                last_of_run,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [sor_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [sor_pkg::DIM_W-1:0]           cfg_data
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int CMP_W  = (CNT_W > sor_pkg::TOT_W) ? CNT_W : sor_pkg::TOT_W;

    logic [sor_pkg::DIM_W-1:0]    num_rows_reg, num_rows_next;
    logic [sor_pkg::DIM_W-1:0]    num_cols_reg, num_cols_next;
    logic [CNT_W-1:0]             load_count_reg, load_count_next;
    logic                         s1_valid_reg, s1_valid_next;
    logic                         s1_last_reg;
    logic                         out_valid_reg, out_valid_next;
    logic [sor_pkg::DATA_W-1:0]   out_value_reg;
    logic                         out_last_reg;
    logic [sor_pkg::DATA_W-1:0]   rd_data_reg;

    logic [sor_pkg::DATA_W-1:0]   store_mem [DEPTH];

    logic                         in_fire;
    logic                         complete;
    logic [CNT_W-1:0]             count_inc;
    logic [sor_pkg::DIM_W-1:0]    rows_eff;
    logic [sor_pkg::DIM_W-1:0]    cols_eff;
    logic [sor_pkg::TOT_W-1:0]    total;
    logic                         walker_busy;
    logic                         advance;
    logic                         s1_move;
    logic [ADDR_W-1:0]            rd_addr;
    sor_pkg::start_t              start;
    sor_pkg::rd_req_t             rd_req;

    assign rows_eff  = sor_pkg::eff_dim(num_rows_reg, MAX_ROWS);
    assign cols_eff  = sor_pkg::eff_dim(num_cols_reg, MAX_COLS);
    assign total     = {{sor_pkg::DIM_W{1'b0}}, rows_eff} * {{sor_pkg::DIM_W{1'b0}}, cols_eff};
    assign in_ready  = !walker_busy;
    assign in_fire   = in_valid && in_ready;
    assign count_inc = load_count_reg + CNT_W'(1);
    assign complete  = (CMP_W'(count_inc) >= CMP_W'(total));
    assign cfg_ready = 1'b1;

    assign start.go    = in_fire && complete;
    assign start.rows  = rows_eff;
    assign start.cols  = cols_eff;
    assign start.total = total;

    sor_walker #(
        .ADDR_W (ADDR_W)
    ) u_walker (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .advance (advance),
        .busy    (walker_busy),
        .rd_req  (rd_req),
        .rd_addr (rd_addr)
    );

    always_comb
    begin
        num_rows_next = num_rows_reg;
        num_cols_next = num_cols_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                sor_pkg::REG_NUM_ROWS: num_rows_next = cfg_data;
                sor_pkg::REG_NUM_COLS: num_cols_next = cfg_data;
                default:               num_rows_next = num_rows_reg;
            endcase
        end
    end

    always_comb
    begin
        load_count_next = load_count_reg;
        if (in_fire)
        begin
            load_count_next = complete ? '0 : count_inc;
        end
    end

    assign s1_move        = s1_valid_reg && (!out_valid_reg || out_ready);
    assign advance        = !s1_valid_reg || s1_move;
    assign s1_valid_next  = rd_req.valid || (s1_valid_reg && !s1_move);
    assign out_valid_next = s1_move || (out_valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_rows_reg   <= sor_pkg::DIM_RESET;
            num_cols_reg   <= sor_pkg::DIM_RESET;
            load_count_reg <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            num_rows_reg   <= num_rows_next;
            num_cols_reg   <= num_cols_next;
            load_count_reg <= load_count_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            store_mem[ADDR_W'(load_count_reg)] <= element_value;
        end
        if (rd_req.valid)
        begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_req.valid)
        begin
            s1_last_reg <= rd_req.last;
        end
        if (s1_move)
        begin
            out_value_reg <= rd_data_reg;
            out_last_reg  <= s1_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign out_value   = $signed(out_value_reg);
    assign last_of_run = out_last_reg;

endmodule

@@ design/sor_checker.sv @@
// Port-level checker for the spiral reorder block, bound to its top level.
// Depends on sor_pkg and spiral_order_reorder_top.
module sor_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic signed [sor_pkg::DATA_W-1:0]   element_value,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [sor_pkg::DATA_W-1:0]   out_value,
    input logic                                last_of_run,
    input logic                                cfg_valid,
    input logic                                cfg_ready,
    input logic [sor_pkg::CFG_IDX_W-1:0]       cfg_index,
    input logic [sor_pkg::DIM_W-1:0]           cfg_data
);

    // A pending result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("out_valid dropped before the item was taken");

    // A pending result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(out_value) && $stable(last_of_run))
        else $error("output payload changed while stalled");

    // The input closes only after the item that completes a matrix.
    a_ready_fall: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(in_ready) |-> $past(in_valid && in_ready))
        else $error("in_ready fell without an accepted item");

    // A fresh result was read while the spiral was running.
    a_out_source: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready, 2))
        else $error("result appeared without a running spiral");

endmodule

bind spiral_order_reorder_top sor_checker u_sor_checker (.*);
